// ===== hw/rtl/hrs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package hrs_pkg;

	localparam int HR_DEPTH    = 16;
	localparam int ACCEL_DEPTH = 4;

	localparam int HR_IDX_W  = $clog2(HR_DEPTH);
	localparam int HR_CNT_W  = $clog2(HR_DEPTH + 1);
	localparam int HR_SUM_W  = 8 + HR_CNT_W;
	localparam int ACC_IDX_W = (ACCEL_DEPTH > 1) ? $clog2(ACCEL_DEPTH) : 1;
	localparam int ACC_TOT_W = 16 + $clog2(ACCEL_DEPTH);
	localparam int MIN_FILL  = 4;

	localparam int DIV_DVD_W = 48;
	localparam int DIV_DVS_W = 32;
	localparam int DIV_CNT_W = 6;

	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_MOTION_THR   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PER   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SCORE_PER    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_SAMPLES = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_BASE = 3'd5;

	// One request from the front to the back.
	typedef struct packed {
		logic        suppress;
		logic        wr_en;
		logic        score_en;
		logic [7:0]  hr;
		logic [15:0] base_q8;
		logic [7:0]  rest;
	} cmd_t;

endpackage
`default_nettype wire

// ===== hw/rtl/hrs_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hrs_div import hrs_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [DIV_DVD_W-1:0] dvd,
	input  wire logic [DIV_DVS_W-1:0] dvs,
	input  wire logic [DIV_CNT_W-1:0] nbits,
	output logic                      done,
	output logic [DIV_DVD_W-1:0]      quo
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_DVD_W-1:0] dvd_q;
	logic [DIV_DVD_W-1:0] quo_q;
	logic [DIV_DVS_W-1:0] dvs_q;
	logic [DIV_DVS_W-1:0] rem_q;
	logic [DIV_DVS_W:0]   trial;
	logic [DIV_DVS_W:0]   rem_n;
	logic                 ge;

	assign trial = {rem_q, dvd_q[DIV_DVD_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign rem_n = ge ? trial - {1'b0, dvs_q} : trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= nbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// Left-align the used low bits of the dividend.
			dvd_q <= dvd << (DIV_CNT_W'(DIV_DVD_W) - nbits);
			dvs_q <= dvs;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIV_DVD_W-2:0], 1'b0};
			rem_q <= rem_n[DIV_DVS_W-1:0];
			quo_q <= {quo_q[DIV_DVD_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule
`default_nettype wire

// ===== hw/rtl/hrs_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hrs_front import hrs_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [55:0]           s_tdata,
	input  wire logic [1:0]            s_tuser,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output logic                       push,
	output cmd_t                       push_cmd,
	input  wire logic                  full
);

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_EVAL = 2'd1;
	localparam logic [1:0] F_DIV  = 2'd2;
	localparam logic [1:0] F_PUSH = 2'd3;
	localparam logic [ACC_TOT_W-1:0] CENTER = ACC_TOT_W'(4096 * ACCEL_DEPTH);

	logic [1:0] st_q;

	logic [31:0] now_s1;
	logic [15:0] accel_s1;
	logic [7:0]  hr_s1;
	logic        hrv_s1;
	logic        stby_s1;

	logic [15:0] thr_q, cool_q, sp_q, scp_q;
	logic [5:0]  bsamp_q;
	logic [7:0]  dflt_q;

	logic [15:0]          hist_q [ACCEL_DEPTH];
	logic [ACC_IDX_W-1:0] aidx_q;
	logic [ACC_TOT_W-1:0] tot_q;
	logic [31:0]          last_motion_q, last_sample_q, last_score_q;
	logic [13:0]          bsum_q;
	logic [5:0]           bcnt_q;
	logic [15:0]          bq8_q;
	logic                 bready_q;
	logic                 sup_q, wr_q, score_q;

	logic [ACC_TOT_W-1:0] tot_n, dev, thr_x;
	logic                 moving, cool, hr_ok, samp_due, score_due, b_fin, suppress;
	logic [13:0]          bsum_n;
	logic [5:0]           bcnt_n;
	logic                 div_start, div_done;
	logic [DIV_DVD_W-1:0] div_quo;

	assign tot_n    = tot_q - ACC_TOT_W'(hist_q[aidx_q]) + ACC_TOT_W'(accel_s1);
	assign dev      = (tot_n > CENTER) ? tot_n - CENTER : CENTER - tot_n;
	assign thr_x    = ACC_TOT_W'(thr_q) * ACC_TOT_W'(ACCEL_DEPTH);
	assign moving   = dev > thr_x;
	// A last motion time of zero means no motion seen yet.
	assign cool     = (last_motion_q != 32'd0) &&
	                  ((now_s1 - last_motion_q) < {16'd0, cool_q});
	assign suppress = moving || cool;
	assign hr_ok    = hrv_s1 && (hr_s1 != 8'd0);
	assign samp_due = (now_s1 - last_sample_q) >= {16'd0, sp_q};
	assign score_due = (now_s1 - last_score_q) >= {16'd0, scp_q};
	assign bsum_n   = bsum_q + 14'(hr_s1);
	assign bcnt_n   = bcnt_q + 6'd1;
	assign b_fin    = samp_due && !bready_q && (bcnt_n >= bsamp_q);
	assign div_start = (st_q == F_EVAL) && !stby_s1 && !suppress && hr_ok && b_fin;

	hrs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.dvd    (DIV_DVD_W'({bsum_n, 8'd0})),
		.dvs    (DIV_DVS_W'(bcnt_n)),
		.nbits  (DIV_CNT_W'(22)),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign s_tready  = (st_q == F_IDLE);
	assign cfg_ready = 1'b1;
	assign push      = (st_q == F_PUSH) && !full;

	always_comb begin
		push_cmd          = '0;
		push_cmd.suppress = sup_q;
		push_cmd.wr_en    = wr_q;
		push_cmd.score_en = score_q;
		push_cmd.hr       = hr_s1;
		push_cmd.base_q8  = bready_q ? bq8_q : {dflt_q, 8'd0};
		push_cmd.rest     = bready_q ? bq8_q[15:8] : hr_s1;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			now_s1   <= s_tdata[31:0];
			accel_s1 <= s_tdata[47:32];
			hr_s1    <= s_tdata[55:48];
			hrv_s1   <= s_tuser[0];
			stby_s1  <= s_tuser[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= 16'd819;
			cool_q  <= 16'd10000;
			sp_q    <= 16'd2000;
			scp_q   <= 16'd5000;
			bsamp_q <= 6'd12;
			dflt_q  <= 8'd72;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MOTION_THR:   thr_q   <= cfg_data;
				REG_COOLDOWN:     cool_q  <= cfg_data;
				REG_SAMPLE_PER:   sp_q    <= cfg_data;
				REG_SCORE_PER:    scp_q   <= cfg_data;
				REG_BASE_SAMPLES: bsamp_q <= cfg_data[5:0];
				REG_DEFAULT_BASE: dflt_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= F_IDLE;
			for (int i = 0; i < ACCEL_DEPTH; i++) hist_q[i] <= 16'd4096;
			aidx_q        <= '0;
			tot_q         <= CENTER;
			last_motion_q <= '0;
			last_sample_q <= '0;
			last_score_q  <= '0;
			bsum_q        <= '0;
			bcnt_q        <= '0;
			bq8_q         <= '0;
			bready_q      <= 1'b0;
			sup_q         <= 1'b0;
			wr_q          <= 1'b0;
			score_q       <= 1'b0;
		end else begin
			unique case (st_q)
				F_IDLE: begin
					if (s_tvalid) st_q <= F_EVAL;
				end
				F_EVAL: begin
					if (stby_s1) begin
						st_q <= F_IDLE;
					end else begin
						tot_q          <= tot_n;
						hist_q[aidx_q] <= accel_s1;
						aidx_q <= (aidx_q == ACC_IDX_W'(ACCEL_DEPTH - 1)) ? '0 : aidx_q + 1'b1;
						if (moving) last_motion_q <= now_s1;
						if (suppress) begin
							sup_q   <= 1'b1;
							wr_q    <= 1'b0;
							score_q <= 1'b0;
							st_q    <= F_PUSH;
						end else if (!hr_ok) begin
							st_q <= F_IDLE;
						end else begin
							sup_q   <= 1'b0;
							wr_q    <= samp_due;
							score_q <= score_due;
							if (samp_due) last_sample_q <= now_s1;
							if (score_due) last_score_q <= now_s1;
							if (samp_due && !bready_q) begin
								bsum_q <= bsum_n;
								bcnt_q <= bcnt_n;
							end
							priority if (b_fin) st_q <= F_DIV;
							else if (samp_due || score_due) st_q <= F_PUSH;
							else st_q <= F_IDLE;
						end
					end
				end
				F_DIV: begin
					if (div_done) begin
						bq8_q    <= div_quo[15:0];
						bready_q <= 1'b1;
						st_q     <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!full) st_q <= F_IDLE;
				end
				default: st_q <= F_IDLE;
			endcase
		end
	end

	a_div_once: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == F_DIV) |-> !bready_q)
		else $error("baseline divide while baseline already ready");

endmodule
`default_nettype wire

// ===== hw/rtl/hrs_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hrs_fifo import hrs_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	output logic      full,
	input  wire logic pop,
	output cmd_t      pop_cmd,
	output logic      empty
);

	cmd_t               ent_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wp_q, rp_q;
	logic [Q_PTR_W:0]   cnt_q;

	assign full    = (cnt_q == (Q_PTR_W+1)'(Q_DEPTH));
	assign empty   = (cnt_q == '0);
	assign pop_cmd = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) ent_q[wp_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("request queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("request queue underflow");

endmodule
`default_nettype wire

// ===== hw/rtl/hrs_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hrs_back import hrs_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  empty,
	input  wire cmd_t  cmd,
	output logic       pop,
	output logic       m_tvalid,
	input  wire logic  m_tready,
	output logic [39:0] m_tdata,
	output logic [0:0]  m_tuser
);

	localparam logic [3:0] B_IDLE    = 4'd0;
	localparam logic [3:0] B_WALK    = 4'd1;
	localparam logic [3:0] B_MEAN_GO = 4'd2;
	localparam logic [3:0] B_MEAN_WT = 4'd3;
	localparam logic [3:0] B_STR_GO  = 4'd4;
	localparam logic [3:0] B_STR_WT  = 4'd5;
	localparam logic [3:0] B_SQ      = 4'd6;
	localparam logic [3:0] B_HRV_GO  = 4'd7;
	localparam logic [3:0] B_HRV_WT  = 4'd8;
	localparam logic [3:0] B_FIN     = 4'd9;

	localparam logic [15:0] LO  = 16'd15360;
	localparam logic [15:0] MID = 16'd21760;
	localparam logic [15:0] HI  = 16'd25600;

	logic [3:0] st_q;

	logic [7:0]          win_q [HR_DEPTH];
	logic [HR_IDX_W-1:0] widx_q;
	logic [HR_CNT_W-1:0] fill_q, fill_n, idx_q;
	logic                rd_v_s1;
	logic [7:0]          rd_s1;
	logic [HR_SUM_W-1:0] sum_q;
	logic [7:0]          mn_q, mx_q, rng_q;
	logic [15:0]         b_q, m_q;
	logic [7:0]          rest_q;
	logic [6:0]          stress_q, hrv_q;
	logic [31:0]         msq_q;
	logic                issue_v;

	logic [6:0] pub_stress_q, pub_hrv_q, pub_rec_q;
	logic [7:0] pub_rest_q;
	logic       pub_avail_q;

	logic       out_v_q;
	logic [6:0] o_stress_q, o_hrv_q, o_rec_q;
	logic [7:0] o_rest_q;
	logic [2:0] o_level_q;
	logic       o_avail_q, o_changed_q;

	logic [20:0] s_num;
	logic [15:0] s_den, s_rng;
	logic [7:0]  s_off, s_sum;
	logic [6:0]  s_val;
	logic [25:0] hrv_num;
	logic [9:0]  rec_x;
	logic [25:0] rec_p;
	logic [6:0]  rec_v;
	logic [2:0]  level_v;
	logic        chg_v;

	logic                 div_start, div_done;
	logic [DIV_DVD_W-1:0] div_dvd, div_quo;
	logic [DIV_DVS_W-1:0] div_dvs;
	logic [DIV_CNT_W-1:0] div_n;

	assign pop     = (st_q == B_IDLE) && !empty && !out_v_q;
	assign fill_n  = (cmd.wr_en && fill_q != HR_CNT_W'(HR_DEPTH)) ? fill_q + 1'b1 : fill_q;
	assign issue_v = (idx_q < fill_q);

	// Piecewise stress bands; offset plus a truncated ratio.
	always_comb begin
		s_rng = '0;
		if (m_q <= LO) begin
			s_num = 21'(m_q) * 21'd20;
			s_den = LO;
			s_off = 8'd0;
		end else if (m_q <= b_q) begin
			s_rng = b_q - LO;
			s_num = 21'(m_q - LO) * 21'd20;
			s_den = (s_rng < 16'd256) ? 16'd256 : s_rng;
			s_off = 8'd20;
		end else if (m_q <= MID) begin
			s_rng = (b_q < MID) ? MID - b_q : 16'd0;
			s_num = 21'(m_q - b_q) * 21'd25;
			s_den = (s_rng < 16'd256) ? 16'd256 : s_rng;
			s_off = 8'd40;
		end else if (m_q < HI) begin
			s_num = 21'(m_q - MID) * 21'd15;
			s_den = HI - MID;
			s_off = 8'd65;
		end else begin
			s_num = 21'(m_q - HI) * 21'd20;
			s_den = 16'd10240;
			s_off = 8'd80;
		end
	end

	assign s_sum   = s_off + div_quo[7:0];
	assign s_val   = (s_sum > 8'd100) ? 7'd100 : s_sum[6:0];
	assign hrv_num = 26'(rng_q) * 26'd180000;

	// Divide by ten as a multiply by the reciprocal, exact for these values.
	assign rec_x = 10'(stress_q) * 10'd9;
	assign rec_p = 26'(rec_x) * 26'd52429;
	assign rec_v = 7'd100 - rec_p[25:19];

	always_comb begin
		priority if (stress_q <= 7'd20) level_v = 3'd0;
		else if (stress_q <= 7'd40) level_v = 3'd1;
		else if (stress_q <= 7'd65) level_v = 3'd2;
		else if (stress_q <= 7'd80) level_v = 3'd3;
		else level_v = 3'd4;
	end

	assign chg_v = (stress_q != pub_stress_q) || (hrv_q != pub_hrv_q) ||
	               (rest_q != pub_rest_q) || (rec_v != pub_rec_q) || !pub_avail_q;

	always_comb begin
		div_start = 1'b0;
		div_dvd   = DIV_DVD_W'({sum_q, 8'd0});
		div_dvs   = DIV_DVS_W'(fill_q);
		div_n     = DIV_CNT_W'(HR_SUM_W + 8);
		unique case (st_q)
			B_MEAN_GO: div_start = 1'b1;
			B_STR_GO: begin
				div_start = 1'b1;
				div_dvd   = DIV_DVD_W'(s_num);
				div_dvs   = DIV_DVS_W'(s_den);
				div_n     = DIV_CNT_W'(21);
			end
			B_HRV_GO: begin
				div_start = 1'b1;
				div_dvd   = DIV_DVD_W'({hrv_num, 16'd0});
				div_dvs   = msq_q;
				div_n     = DIV_CNT_W'(42);
			end
			default: ;
		endcase
	end

	hrs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.dvd    (div_dvd),
		.dvs    (div_dvs),
		.nbits  (div_n),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk) begin
		if (pop && cmd.wr_en) win_q[widx_q] <= cmd.hr;
		rd_s1 <= win_q[idx_q[HR_IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= B_IDLE;
			widx_q       <= '0;
			fill_q       <= '0;
			idx_q        <= '0;
			rd_v_s1      <= 1'b0;
			pub_stress_q <= '0;
			pub_hrv_q    <= '0;
			pub_rest_q   <= '0;
			pub_rec_q    <= '0;
			pub_avail_q  <= 1'b0;
			out_v_q      <= 1'b0;
		end else begin
			if (out_v_q && m_tready) out_v_q <= 1'b0;
			rd_v_s1 <= (st_q == B_WALK) && issue_v;
			unique case (st_q)
				B_IDLE: begin
					if (pop) begin
						if (cmd.wr_en) begin
							widx_q <= (widx_q == HR_IDX_W'(HR_DEPTH - 1)) ? '0 : widx_q + 1'b1;
						end
						fill_q <= fill_n;
						if (cmd.suppress) begin
							out_v_q      <= 1'b1;
							o_stress_q   <= '0;
							o_hrv_q      <= '0;
							o_rest_q     <= '0;
							o_rec_q      <= '0;
							o_level_q    <= '0;
							o_avail_q    <= 1'b0;
							o_changed_q  <= (pub_stress_q != '0) || (pub_hrv_q != '0) ||
							                (pub_rest_q != '0) || (pub_rec_q != '0) ||
							                pub_avail_q;
							pub_stress_q <= '0;
							pub_hrv_q    <= '0;
							pub_rest_q   <= '0;
							pub_rec_q    <= '0;
							pub_avail_q  <= 1'b0;
						end else if (cmd.score_en && fill_n >= HR_CNT_W'(MIN_FILL)) begin
							b_q    <= cmd.base_q8;
							rest_q <= cmd.rest;
							idx_q  <= '0;
							sum_q  <= '0;
							mn_q   <= 8'd255;
							mx_q   <= 8'd0;
							st_q   <= B_WALK;
						end
					end
				end
				B_WALK: begin
					if (issue_v) idx_q <= idx_q + 1'b1;
					if (rd_v_s1) begin
						sum_q <= sum_q + HR_SUM_W'(rd_s1);
						if (rd_s1 < mn_q) mn_q <= rd_s1;
						if (rd_s1 > mx_q) mx_q <= rd_s1;
					end
					if (!issue_v && !rd_v_s1) st_q <= B_MEAN_GO;
				end
				B_MEAN_GO: st_q <= B_MEAN_WT;
				B_MEAN_WT: begin
					if (div_done) begin
						m_q  <= div_quo[15:0];
						st_q <= B_STR_GO;
					end
				end
				B_STR_GO: st_q <= B_STR_WT;
				B_STR_WT: begin
					if (div_done) begin
						stress_q <= s_val;
						st_q     <= B_SQ;
					end
				end
				B_SQ: begin
					msq_q <= 32'(m_q) * 32'(m_q);
					rng_q <= mx_q - mn_q;
					if (mx_q == mn_q) begin
						hrv_q <= 7'd18;
						st_q  <= B_FIN;
					end else begin
						st_q <= B_HRV_GO;
					end
				end
				B_HRV_GO: st_q <= B_HRV_WT;
				B_HRV_WT: begin
					if (div_done) begin
						if (div_quo > DIV_DVD_W'(120)) hrv_q <= 7'd120;
						else if (div_quo < DIV_DVD_W'(10)) hrv_q <= 7'd10;
						else hrv_q <= div_quo[6:0];
						st_q <= B_FIN;
					end
				end
				B_FIN: begin
					out_v_q      <= 1'b1;
					o_stress_q   <= stress_q;
					o_hrv_q      <= hrv_q;
					o_rest_q     <= rest_q;
					o_rec_q      <= rec_v;
					o_level_q    <= level_v;
					o_avail_q    <= 1'b1;
					o_changed_q  <= chg_v;
					pub_stress_q <= stress_q;
					pub_hrv_q    <= hrv_q;
					pub_rest_q   <= rest_q;
					pub_rec_q    <= rec_v;
					pub_avail_q  <= 1'b1;
					st_q         <= B_IDLE;
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = o_avail_q;
	assign m_tdata  = {7'd0, o_changed_q, o_level_q, o_rec_q, o_rest_q, o_hrv_q, o_stress_q};

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= HR_CNT_W'(HR_DEPTH))
		else $error("window fill count beyond depth");

	a_suppress_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata[31:0] == 32'd0))
		else $error("suppression result carries nonzero values");

endmodule
`default_nettype wire

// ===== hw/rtl/hr_stress_score_estimator_core.sv =====
// Path: a suppression result can leave once its item is accepted and queued; a score result
// follows a walk of up to 16 window reads, then divider passes of 21, 21 and 42 bit steps
// (the last skipped for a flat window), and a further front-end divide when it finalizes the
// baseline. Flow: the front takes no new item while it evaluates one, divides or waits to queue
// a request; the back end takes no new request until its last result has been taken.
// Reset: asynchronous, clears all control state and loads register reset values.
`timescale 1ns / 1ps
`default_nettype none
module hr_stress_score_estimator_core import hrs_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [55:0]           s_tdata,   // now_ms, accel_mag, hr_bpm
	input  wire logic [1:0]            s_tuser,   // hr_valid, standby
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [39:0]                m_tdata,   // stress_score, hrv_value, resting_hr,
	                                              // recovery_score, level_code, changed
	output logic [0:0]                 m_tuser,   // available
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic push, pop, full, empty;
	cmd_t push_cmd, pop_cmd;

	hrs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (full)
	);

	hrs_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.empty    (empty)
	);

	hrs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (empty),
		.cmd      (pop_cmd),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
	import hrs_pkg::*;

	typedef struct {
		bit [6:0] stress;
		bit [6:0] hrv;
		bit [7:0] rest;
		bit [6:0] recovery;
		bit [2:0] level;
		bit       available;
		bit       changed;
	} stress_result_t;

	class stress_scoreboard;
		int unsigned    motion_thr, cooldown, sample_per, score_per, base_samples, default_bpm;
		bit [7:0]       hr_ring [HR_DEPTH];
		int unsigned    ring_wr, ring_fill;
		int unsigned    base_sum, base_cnt, base_q8;
		bit             base_ready;
		int unsigned    accel_hist [ACCEL_DEPTH];
		int unsigned    accel_wr, accel_sum;
		bit [31:0]      last_motion, last_sample, last_score;
		stress_result_t published;
		stress_result_t expected_q [$];
		int             errors;

		function new();
			motion_thr = 819;
			cooldown = 10000;
			sample_per = 2000;
			score_per = 5000;
			base_samples = 12;
			default_bpm = 72;
			ring_wr = 0;
			ring_fill = 0;
			base_sum = 0;
			base_cnt = 0;
			base_q8 = 0;
			base_ready = 0;
			foreach (accel_hist[i]) accel_hist[i] = 4096;
			accel_wr = 0;
			accel_sum = 4096 * ACCEL_DEPTH;
			last_motion = 0;
			last_sample = 0;
			last_score = 0;
			published = '{default: 0};
			errors = 0;
		endfunction

		task report(string msg);
			$display("ERROR at %0t: %s", $realtime, msg);
			errors++;
		endtask

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_MOTION_THR:   motion_thr = val;
				REG_COOLDOWN:     cooldown = val;
				REG_SAMPLE_PER:   sample_per = val;
				REG_SCORE_PER:    score_per = val;
				REG_BASE_SAMPLES: base_samples = val[5:0];
				REG_DEFAULT_BASE: default_bpm = val[7:0];
				default: ;
			endcase
		endfunction

		function int unsigned stress_of(int unsigned m, int unsigned b);
			int unsigned span, s;
			if (m <= 60 * 256)
				return (m * 20) / (60 * 256);
			if (m <= b) begin
				span = b - 60 * 256;
				if (span < 256)
					span = 256;
				return 20 + ((m - 60 * 256) * 20) / span;
			end
			if (m <= 85 * 256) begin
				span = (b < 85 * 256) ? 85 * 256 - b : 0;
				if (span < 256)
					span = 256;
				return 40 + ((m - b) * 25) / span;
			end
			if (m < 100 * 256)
				return 65 + ((m - 85 * 256) * 15) / (15 * 256);
			s = 80 + ((m - 100 * 256) * 20) / (40 * 256);
			return (s > 100) ? 100 : s;
		endfunction

		function int unsigned level_of(int unsigned s);
			if (s <= 20) return 0;
			if (s <= 40) return 1;
			if (s <= 65) return 2;
			if (s <= 80) return 3;
			return 4;
		endfunction

		function bit same_values(stress_result_t a, stress_result_t b);
			return a.stress == b.stress && a.hrv == b.hrv && a.rest == b.rest &&
				a.recovery == b.recovery && a.available == b.available;
		endfunction

		// Called for every accepted input request; queues the result it causes, if any.
		function void note_input(bit [31:0] now, bit [15:0] accel, bit [7:0] hr, bit hr_ok,
				bit standby);
			int unsigned    dev, sum, mn, mx, m, b, s, span;
			longint unsigned q;
			bit             moving;
			stress_result_t r;
			if (standby)
				return;
			accel_sum = accel_sum - accel_hist[accel_wr] + accel;
			accel_hist[accel_wr] = accel;
			accel_wr = (accel_wr + 1) % ACCEL_DEPTH;
			dev = (accel_sum > 4096 * ACCEL_DEPTH) ? accel_sum - 4096 * ACCEL_DEPTH
				: 4096 * ACCEL_DEPTH - accel_sum;
			moving = dev > motion_thr * ACCEL_DEPTH;
			if (moving || (last_motion != 0 && 32'(now - last_motion) < cooldown)) begin
				if (moving)
					last_motion = now;
				r = '{default: 0};
				r.changed = published.stress != 0 || published.hrv != 0 || published.rest != 0
					|| published.recovery != 0 || published.available;
				published = r;
				expected_q.push_back(r);
				return;
			end
			if (!hr_ok || hr == 0)
				return;
			if (32'(now - last_sample) >= sample_per) begin
				last_sample = now;
				hr_ring[ring_wr] = hr;
				ring_wr = (ring_wr + 1) % HR_DEPTH;
				if (ring_fill < HR_DEPTH)
					ring_fill++;
				if (!base_ready) begin
					base_sum += hr;
					base_cnt++;
					if (base_cnt >= base_samples) begin
						base_q8 = (base_sum * 256) / base_cnt;
						base_ready = 1;
					end
				end
			end
			if (32'(now - last_score) < score_per)
				return;
			last_score = now;
			if (ring_fill < MIN_FILL)
				return;
			sum = 0;
			mn = 255;
			mx = 0;
			for (int i = 0; i < ring_fill; i++) begin
				sum += hr_ring[i];
				if (hr_ring[i] < mn) mn = hr_ring[i];
				if (hr_ring[i] > mx) mx = hr_ring[i];
			end
			m = (sum * 256) / ring_fill;
			b = base_ready ? base_q8 : default_bpm * 256;
			s = stress_of(m, b);
			r.stress = s;
			r.recovery = 100 - (s * 9) / 10;
			r.rest = base_ready ? base_q8[15:8] : hr;
			span = mx - mn;
			if (span == 0)
				r.hrv = 18;
			else if (m == 0)
				r.hrv = 0;
			else begin
				q = (longint'(span) * 180000 * 65536) / (longint'(m) * m);
				r.hrv = (q > 120) ? 120 : (q < 10) ? 10 : q;
			end
			r.level = level_of(s);
			r.available = 1;
			r.changed = !same_values(r, published);
			published = r;
			expected_q.push_back(r);
		endfunction

		task check_result(logic [39:0] data, logic [0:0] user);
			stress_result_t e;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected result data=%h user=%b", data, user));
				return;
			end
			e = expected_q.pop_front();
			if (data[6:0] !== e.stress)
				report($sformatf("stress %0d, expected %0d", data[6:0], e.stress));
			if (data[13:7] !== e.hrv)
				report($sformatf("hrv %0d, expected %0d", data[13:7], e.hrv));
			if (data[21:14] !== e.rest)
				report($sformatf("resting hr %0d, expected %0d", data[21:14], e.rest));
			if (data[28:22] !== e.recovery)
				report($sformatf("recovery %0d, expected %0d", data[28:22], e.recovery));
			if (data[31:29] !== e.level)
				report($sformatf("level %0d, expected %0d", data[31:29], e.level));
			if (data[32] !== e.changed)
				report($sformatf("changed %b, expected %b", data[32], e.changed));
			if (user[0] !== e.available)
				report($sformatf("available %b, expected %b", user[0], e.available));
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [55:0]           s_tdata;
	logic [1:0]            s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [39:0]           m_tdata;
	logic [0:0]            m_tuser;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	stress_scoreboard scoreboard = new();
	bit [31:0]        clock_ms;
	bit               stall_heavy;

	hr_stress_score_estimator_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			scoreboard.check_result(m_tdata, m_tuser);
	end

	// Result side: runs of ready and stall, mostly short with an occasional long stall.
	initial begin
		int unsigned n;
		m_tready = 1'b0;
		forever begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
			m_tready <= 1'b1;
			repeat (stall_heavy ? 1 : n) @(posedge clk);
			if ($urandom_range(0, 3) != 0 || stall_heavy) begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 4);
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
		end
	end

	task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		scoreboard.write_reg(idx, val);
		cfg_valid <= 1'b0;
	endtask

	task set_config(int unsigned thr, int unsigned cool, int unsigned sper, int unsigned cper,
			int unsigned bsamp, int unsigned dflt);
		write_reg(REG_MOTION_THR, CFG_DATA_W'(thr));
		write_reg(REG_COOLDOWN, CFG_DATA_W'(cool));
		write_reg(REG_SAMPLE_PER, CFG_DATA_W'(sper));
		write_reg(REG_SCORE_PER, CFG_DATA_W'(cper));
		write_reg(REG_BASE_SAMPLES, CFG_DATA_W'(bsamp));
		write_reg(REG_DEFAULT_BASE, CFG_DATA_W'(dflt));
	endtask

	// Items that give no result may still be in the back end; allow for a full score pass.
	task wait_drained();
		while (scoreboard.expected_q.size() != 0)
			@(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task send_update(bit [31:0] now, bit [15:0] accel, bit [7:0] hr, bit hr_ok, bit standby,
			int unsigned gap);
		s_tvalid <= 1'b1;
		s_tdata <= {hr, accel, now};
		s_tuser <= {standby, hr_ok};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		scoreboard.note_input(now, accel, hr, hr_ok, standby);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task send_random(int unsigned count, int unsigned step_lo, int unsigned step_hi);
		int unsigned pick, gap;
		bit [15:0]   accel;
		bit [7:0]    hr;
		bit          hr_ok;
		for (int k = 0; k < count; k++) begin
			clock_ms += $urandom_range(step_lo, step_hi);
			pick = $urandom_range(0, 99);
			if (pick < 85)
				accel = 16'd3896 + 16'($urandom_range(0, 400));
			else if (pick < 95)
				accel = $urandom_range(0, 1) ? 16'($urandom_range(9000, 65535))
					: 16'($urandom_range(0, 1500));
			else
				accel = 16'($urandom);
			pick = $urandom_range(0, 99);
			hr = (pick < 90) ? 8'($urandom_range(45, 190)) : (pick < 93) ? 8'd0 : 8'($urandom);
			hr_ok = $urandom_range(0, 99) >= 5;
			pick = $urandom_range(0, 99);
			gap = (pick < 60) ? 0 : (pick < 92) ? $urandom_range(1, 3) : $urandom_range(10, 60);
			send_update(clock_ms, accel, hr, hr_ok, $urandom_range(0, 99) < 3, gap);
		end
		s_tvalid <= 1'b0;
	endtask

	initial begin
		bit [7:0] flat_hr [10] = '{80, 80, 80, 80, 80, 255, 1, 200, 40, 120};
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		stall_heavy = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: standby, motion at time zero, motion with cooldown, missing heart rate,
		// then a flat window followed by extreme rates, all under reset settings.
		send_update(32'd0, 16'hFFFF, 8'd90, 1'b1, 1'b1, 0);
		send_update(32'd0, 16'hFFFF, 8'd90, 1'b1, 1'b0, 0);
		send_update(32'd10, 16'h0000, 8'd90, 1'b1, 1'b0, 1);
		send_update(32'd20, 16'd4096, 8'd90, 1'b1, 1'b0, 0);
		send_update(32'd30, 16'd4096, 8'd90, 1'b1, 1'b0, 0);
		send_update(32'd40, 16'd4096, 8'd90, 1'b1, 1'b0, 0);
		send_update(32'd12000, 16'd4096, 8'd0, 1'b1, 1'b0, 0);
		send_update(32'd12500, 16'd4096, 8'd90, 1'b0, 1'b0, 0);
		clock_ms = 20000;
		foreach (flat_hr[i]) begin
			clock_ms += 5000;
			send_update(clock_ms, 16'd4096, flat_hr[i], 1'b1, 1'b0, 2);
		end
		wait_drained();

		clock_ms = $urandom;
		send_random(200, 200, 3000);
		wait_drained();

		set_config(819, 500, 50, 120, 1, 255);
		send_random(300, 20, 300);
		wait_drained();

		set_config(65535, 0, 1, 1, 63, 0);
		stall_heavy = 1'b1;
		send_random(250, 0, 5);
		stall_heavy = 1'b0;
		wait_drained();

		set_config(0, 65535, 65535, 65535, 1, 72);
		send_random(100, 1000, 40000);
		wait_drained();

		set_config(400, 300, 30, 100, 4, 100);
		send_random(150, 10, 200);
		s_tvalid <= 1'b0;
		while (scoreboard.expected_q.size() != 0)
			@(posedge clk);
		send_random(200, 10, 200);
		s_tvalid <= 1'b0;
		wait_drained();

		while (scoreboard.expected_q.size() != 0) begin
			scoreboard.report("expected result never arrived");
			void'(scoreboard.expected_q.pop_front());
		end
		if (scoreboard.errors == 0)
			$display("hr_stress_score_estimator_core regression: pass");
		else
			$display("hr_stress_score_estimator_core regression: fail");
		$finish;
	end

	initial begin
		#20ms;
		$display("hr_stress_score_estimator_core regression: fail");
		$finish;
	end

endmodule
